### hdl/hv_pkg.sv
// Shared types and constants for the host name checker.
package hv_pkg;

    localparam int DEFAULT_CHARSET_SIZE = 128;
    localparam int QUEUE_DEPTH          = 2;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_CASE_ONLY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LABEL_SET_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LABEL_SET_HIGH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEP_SET_LOW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEP_SET_HIGH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH      = 3'd5;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd254;
    localparam logic [7:0] CHAR_HYPHEN      = 8'h2d;
    localparam logic [7:0] CHAR_DOT         = 8'h2e;

    typedef struct packed {
        logic         lower_case_only;
        logic [127:0] label_set;
        logic [127:0] sep_set;
        logic [7:0]   max_length;
    } cfg_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic no_char;
        logic last;
        logic is_label;
        logic is_hyphen;
        logic is_dot;
        logic is_sep;
    } class_word_t;

endpackage

### hdl/hv_front.sv
// Front end: accepts input words and classifies each byte into a registered word.
module hv_front
    import hv_pkg::*;
#(
    parameter int CHARSET_SIZE = DEFAULT_CHARSET_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_no_char,
    input  logic        s_last,
    output logic        f_valid,
    input  logic        f_ready,
    output class_word_t f_word
);

    logic        valid_reg, valid_next;
    class_word_t word_reg;
    class_word_t word_next;

    logic is_lower, is_upper, is_digit, in_range;

    always_comb begin
        is_lower = (s_char_code >= 8'h61) && (s_char_code <= 8'h7a);
        is_upper = (s_char_code >= 8'h41) && (s_char_code <= 8'h5a);
        is_digit = (s_char_code >= 8'h30) && (s_char_code <= 8'h39);
        // Only 7-bit codes below the character set size can be in a bitmap.
        in_range = !s_char_code[7] && ({1'b0, s_char_code} < 9'(CHARSET_SIZE));

        word_next.no_char   = s_no_char;
        word_next.last      = s_last;
        word_next.is_hyphen = (s_char_code == CHAR_HYPHEN);
        word_next.is_dot    = (s_char_code == CHAR_DOT);
        word_next.is_label  = is_lower || (is_upper && !cfg.lower_case_only) || is_digit
                            || word_next.is_hyphen
                            || (in_range && cfg.label_set[s_char_code[6:0]]);
        word_next.is_sep    = in_range && cfg.sep_set[s_char_code[6:0]];
    end

    assign s_ready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= word_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_word  = word_reg;

endmodule

### hdl/hv_queue.sv
// Short queue of classified words between the front and the back.
module hv_queue
    import hv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  class_word_t in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output class_word_t out_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    class_word_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_word;
        end
    end

endmodule

### hdl/hv_back.sv
// Back end: runs the label and segment rules and drives the result word.
module hv_back
    import hv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  max_length,
    input  logic        q_valid,
    output logic        q_ready,
    input  class_word_t q_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res
);

    logic       at_label_start_reg, at_label_start_next;
    logic       last_was_hyphen_reg, last_was_hyphen_next;
    logic       segment_empty_reg, segment_empty_next;
    logic       failed_reg, failed_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_res_reg, out_res_next;
    logic       take;

    // A word that ends a name waits until the output register can hold its result.
    assign q_ready = !q_word.last || !out_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    always_comb begin
        at_label_start_next  = at_label_start_reg;
        last_was_hyphen_next = last_was_hyphen_reg;
        segment_empty_next   = segment_empty_reg;
        failed_next          = failed_reg;
        byte_count_next      = byte_count_reg;
        out_valid_next       = out_valid_reg && !m_ready;
        out_res_next         = out_res_reg;

        if (take) begin
            if (!q_word.no_char) begin
                if (byte_count_reg >= max_length) begin
                    failed_next = 1'b1;
                end else begin
                    byte_count_next = byte_count_reg + 1'b1;
                end

                if (at_label_start_reg && (q_word.is_hyphen || q_word.is_dot)) begin
                    failed_next = 1'b1;
                end else if (q_word.is_label) begin
                    last_was_hyphen_next = q_word.is_hyphen;
                    segment_empty_next   = 1'b0;
                    at_label_start_next  = 1'b0;
                end else begin
                    if (last_was_hyphen_reg) begin
                        failed_next = 1'b1;
                    end
                    last_was_hyphen_next = 1'b0;
                    if (q_word.is_dot) begin
                        at_label_start_next = 1'b1;
                    end else if (q_word.is_sep) begin
                        at_label_start_next = 1'b1;
                        segment_empty_next  = 1'b1;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
            end

            if (q_word.last) begin
                out_valid_next       = 1'b1;
                out_res_next         = !failed_next && !segment_empty_next
                                     && !last_was_hyphen_next;
                at_label_start_next  = 1'b1;
                last_was_hyphen_next = 1'b0;
                segment_empty_next   = 1'b1;
                failed_next          = 1'b0;
                byte_count_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_label_start_reg  <= 1'b1;
            last_was_hyphen_reg <= 1'b0;
            segment_empty_reg   <= 1'b1;
            failed_reg          <= 1'b0;
            byte_count_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            at_label_start_reg  <= at_label_start_next;
            last_was_hyphen_reg <= last_was_hyphen_next;
            segment_empty_reg   <= segment_empty_next;
            failed_reg          <= failed_next;
            byte_count_reg      <= byte_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_res_reg;

    // The byte count stays within the configured limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_count_reg <= max_length) || (byte_count_reg == '0))
        else $error("byte count ran past the length limit");

    // After the final word of a name the running state is back at its start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_word.last) |=> (at_label_start_reg && segment_empty_reg
                                   && !failed_reg && (byte_count_reg == '0)))
        else $error("state not cleared after end of name");

    // A last word is never taken while a result is stuck in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_word.last) |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

### hdl/hostname_validator.sv
// Top level of the streaming host name checker.
//
// Input channel (s_valid/s_ready): one word per byte of the name, with
// s_char_code, s_no_char for an empty name, and s_last on the final word.
// Output channel (m_valid/m_ready): one word with m_valid_res for each
// input word marked last; 1 means the name is a valid host name.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index;
// change it only while no name is in flight.
// Throughput is one byte per cycle while no stall holds the flow. The front
// classifies a byte in one register stage, a two-word queue follows, and the
// back updates the running label state and registers the result. The back's
// label state update for each byte it takes sets the one-byte-per-cycle rate.
// A stalled receiver first fills the output register; the next last word
// then waits in the back, the queue and the front register fill behind it,
// and only then does s_ready drop.
// Reset (aresetn low, synchronous) empties all stages, clears the name state,
// and sets the registers to defaults: all sets empty, mixed case, limit 254.
module hostname_validator
    import hv_pkg::*;
#(
    parameter int CHARSET_SIZE = DEFAULT_CHARSET_SIZE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_char_code,
    input  logic                   s_no_char,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_valid_res
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        f_valid, f_ready;
    class_word_t f_word;
    logic        q_valid, q_ready;
    class_word_t q_word;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOWER_CASE_ONLY: cfg_next.lower_case_only = cfg_wdata[0];
                REG_LABEL_SET_LOW:   cfg_next.label_set[63:0]   = cfg_wdata;
                REG_LABEL_SET_HIGH:  cfg_next.label_set[127:64] = cfg_wdata;
                REG_SEP_SET_LOW:     cfg_next.sep_set[63:0]     = cfg_wdata;
                REG_SEP_SET_HIGH:    cfg_next.sep_set[127:64]   = cfg_wdata;
                REG_MAX_LENGTH:      cfg_next.max_length        = cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_case_only <= 1'b0;
            cfg_reg.label_set       <= '0;
            cfg_reg.sep_set         <= '0;
            cfg_reg.max_length      <= MAX_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hv_front #(
        .CHARSET_SIZE(CHARSET_SIZE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_no_char   (s_no_char),
        .s_last      (s_last),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_word      (f_word)
    );

    hv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    hv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_length  (cfg_reg.max_length),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_word      (q_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

endmodule

### sim/testbench.sv
// Self-checking testbench for the streaming host name checker.
`timescale 1ns / 100ps

module testbench;
    import hv_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 50;
    localparam int DIR_ROWS     = 25;

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_char_code = 8'h00;
    logic                   s_no_char   = 1'b0;
    logic                   s_last      = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic                   m_valid_res;

    hostname_validator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_no_char   (s_no_char),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

    // Checker copy of the registers and of the running name state.
    cfg_t chk_cfg = '{lower_case_only: 1'b0, label_set: '0, sep_set: '0,
                      max_length: MAX_LENGTH_RESET};
    bit       lbl_start   = 1'b1;
    bit       prev_hyphen = 1'b0;
    bit       seg_empty   = 1'b1;
    bit       name_bad    = 1'b0;
    bit [7:0] name_len    = 8'd0;

    bit valid_res_q[$];
    int mismatch_cnt = 0;
    int words_sent   = 0;
    int cycle_cnt    = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_off_req = 1'b0;
    bit want_res;

    typedef struct packed {
        logic [7:0] code;
        logic       no_char;
        logic       last;
        logic       typed;
        logic       typed_res;
    } dir_row_t;

    // Every row goes through the name scanner; rows with typed = 1 carry their
    // verdict directly, the rest take the scanner's verdict.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{8'h00,       1'b1, 1'b1, 1'b1, 1'b0},  // empty name
        '{"Z",         1'b0, 1'b1, 1'b0, 1'b0},
        '{8'hff,       1'b0, 1'b1, 1'b1, 1'b0},  // top code
        '{CHAR_HYPHEN, 1'b0, 1'b1, 1'b1, 1'b0},  // hyphen start, also a separator
        '{CHAR_DOT,    1'b0, 1'b1, 1'b1, 1'b0},  // dot start, also a separator
        '{"a",         1'b0, 1'b0, 1'b0, 1'b0},
        '{CHAR_HYPHEN, 1'b0, 1'b1, 1'b1, 1'b0},  // label ends in hyphen
        '{"a",         1'b0, 1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,    1'b0, 1'b1, 1'b0, 1'b0},  // trailing dot
        '{",",         1'b0, 1'b0, 1'b0, 1'b0},  // separator first
        '{"b",         1'b0, 1'b1, 1'b0, 1'b0},
        '{"a",         1'b0, 1'b0, 1'b0, 1'b0},
        '{",",         1'b0, 1'b1, 1'b1, 1'b0},  // empty final segment
        '{8'h00,       1'b0, 1'b0, 1'b0, 1'b0},  // byte zero from the label set
        '{"_",         1'b0, 1'b1, 1'b0, 1'b0},
        '{8'h55,       1'b1, 1'b0, 1'b0, 1'b0},  // word without a byte, ignored
        '{"9",         1'b0, 1'b1, 1'b0, 1'b0},
        '{"a",         1'b0, 1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,    1'b0, 1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,    1'b0, 1'b1, 1'b0, 1'b0},  // dot at label start
        '{8'h80,       1'b0, 1'b1, 1'b1, 1'b0},  // above the character set
        '{"a",         1'b0, 1'b0, 1'b0, 1'b0},
        '{CHAR_HYPHEN, 1'b0, 1'b0, 1'b0, 1'b0},
        '{"b",         1'b0, 1'b1, 1'b0, 1'b0},
        '{"~",         1'b0, 1'b1, 1'b1, 1'b0}   // lone separator
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit char_in(logic [127:0] set, logic [7:0] c);
        return !c[7] && set[c[6:0]];
    endfunction

    // Advances the name state by one word; a verdict comes with the last word.
    task automatic scan_word(input logic [7:0] c, input logic nc, input logic lst,
                             output bit ok);
        bit lbl;
        ok = 1'b0;
        if (!nc) begin
            if (name_len >= chk_cfg.max_length)
                name_bad = 1'b1;
            else
                name_len++;
            if (lbl_start && (c == CHAR_HYPHEN || c == CHAR_DOT)) begin
                name_bad = 1'b1;
            end else begin
                lbl = (c >= "a" && c <= "z")
                    || (c >= "A" && c <= "Z" && !chk_cfg.lower_case_only)
                    || (c >= "0" && c <= "9") || c == CHAR_HYPHEN
                    || char_in(chk_cfg.label_set, c);
                if (lbl) begin
                    prev_hyphen = (c == CHAR_HYPHEN);
                    seg_empty   = 1'b0;
                    lbl_start   = 1'b0;
                end else begin
                    if (prev_hyphen)
                        name_bad = 1'b1;
                    prev_hyphen = 1'b0;
                    if (c == CHAR_DOT) begin
                        lbl_start = 1'b1;
                    end else if (char_in(chk_cfg.sep_set, c)) begin
                        lbl_start = 1'b1;
                        seg_empty = 1'b1;
                    end else begin
                        name_bad = 1'b1;
                    end
                end
            end
        end
        if (lst) begin
            ok          = !name_bad && !seg_empty && !prev_hyphen;
            lbl_start   = 1'b1;
            prev_hyphen = 1'b0;
            seg_empty   = 1'b1;
            name_bad    = 1'b0;
            name_len    = 8'd0;
        end
    endtask

    task automatic send_word(input logic [7:0] c, input logic nc, input logic lst,
                             input bit typed, input bit typed_res);
        bit ok;
        if (tx_idle_on) begin
            while ($urandom_range(99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_no_char   <= nc;
        s_last      <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        scan_word(c, nc, lst, ok);
        if (lst)
            valid_res_q.push_back(typed ? typed_res : ok);
        if (!nc || lst)
            words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (valid_res_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Registers change only once the block holds no word of any name.
    task automatic set_config(input bit strict, input logic [63:0] lab_lo,
                              input logic [63:0] lab_hi, input logic [63:0] sep_lo,
                              input logic [63:0] sep_hi, input logic [7:0] max_len);
        wait_drained();
        write_reg(REG_LOWER_CASE_ONLY, {63'd0, strict});
        write_reg(REG_LABEL_SET_LOW, lab_lo);
        write_reg(REG_LABEL_SET_HIGH, lab_hi);
        write_reg(REG_SEP_SET_LOW, sep_lo);
        write_reg(REG_SEP_SET_HIGH, sep_hi);
        write_reg(REG_MAX_LENGTH, {56'd0, max_len});
        cfg_wr_en <= 1'b0;
        chk_cfg.lower_case_only = strict;
        chk_cfg.label_set       = {lab_hi, lab_lo};
        chk_cfg.sep_set         = {sep_hi, sep_lo};
        chk_cfg.max_length      = max_len;
    endtask

    function automatic logic [7:0] pick_member(logic [127:0] set, logic [7:0] fallback);
        int n;
        int pick;
        n = $countones(set);
        if (n == 0)
            return fallback;
        pick = $urandom_range(n - 1);
        for (int i = 0; i < 128; i++) begin
            if (set[i]) begin
                if (pick == 0)
                    return 8'(i);
                pick--;
            end
        end
        return fallback;
    endfunction

    function automatic logic [7:0] pick_label(bit inner);
        case ($urandom_range(5))
            0, 1: return "a" + 8'($urandom_range(25));
            2: begin
                if (chk_cfg.lower_case_only && $urandom_range(3) != 0)
                    return "a" + 8'($urandom_range(25));
                return "A" + 8'($urandom_range(25));
            end
            3: return "0" + 8'($urandom_range(9));
            4: return inner ? CHAR_HYPHEN : "b";
            default: return pick_member(chk_cfg.label_set, "c");
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(4))
            0: return CHAR_HYPHEN;
            1: return CHAR_DOT;
            2: return 8'($urandom_range(255));
            3: return pick_label(1'b1);
            default: return pick_member(chk_cfg.sep_set, CHAR_DOT);
        endcase
    endfunction

    // Mostly well-formed names with random content; the rest are empty names,
    // damaged names and noise.
    task automatic send_random_name();
        logic [8:0] name_q[$];
        int kind;
        int nseg;
        int nlab;
        int len;
        kind = $urandom_range(99);
        if (kind < 72) begin
            nseg = (chk_cfg.sep_set != '0) ? $urandom_range(1, 3) : 1;
            for (int sg = 0; sg < nseg; sg++) begin
                if (sg != 0)
                    name_q.push_back({1'b0, pick_member(chk_cfg.sep_set, CHAR_DOT)});
                nlab = $urandom_range(1, 3);
                for (int lb = 0; lb < nlab; lb++) begin
                    if (lb != 0)
                        name_q.push_back({1'b0, CHAR_DOT});
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        name_q.push_back({1'b0, pick_label(k != 0 && k != len - 1)});
                end
            end
            if ($urandom_range(9) == 0)
                name_q.push_back({1'b0, CHAR_DOT});
            if ($urandom_range(7) == 0)
                name_q[$urandom_range(name_q.size() - 1)] = {1'b0, pick_noise()};
        end else if (kind >= 77) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                name_q.push_back({1'b0, pick_noise()});
        end
        if (name_q.size() != 0 && $urandom_range(19) == 0)
            name_q.insert($urandom_range(name_q.size() - 1),
                          {1'b1, 8'($urandom_range(255))});
        if (name_q.size() == 0 || $urandom_range(19) == 0)
            name_q.push_back({1'b1, 8'($urandom_range(255))});
        foreach (name_q[i])
            send_word(name_q[i][7:0], name_q[i][8], i == name_q.size() - 1, 1'b0, 1'b0);
    endtask

    task automatic run_names(input int n);
        int start;
        start = words_sent;
        while (words_sent - start < n)
            send_random_name();
    endtask

    // A long dotted name of n bytes, to cross the length limit.
    task automatic send_long_name(input int n);
        for (int k = 0; k < n; k++)
            send_word((k % 8 == 7) ? CHAR_DOT : "a", 1'b0, k == n - 1, 1'b0, 1'b0);
    endtask

    // Receiver: random stalls, a quiet stretch on request, one long hold-off.
    initial begin
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !rx_idle_on || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (valid_res_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t: unexpected word, expected none, got valid_res %0b",
                             $time, m_valid_res);
            end else begin
                want_res = valid_res_q.pop_front();
                if (m_valid_res !== want_res) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: valid_res mismatch, expected %0b, got %0b",
                                 $time, want_res, m_valid_res);
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Hyphen, dot, comma and tilde are separators; dot still acts as a dot.
        set_config(1'b0, 64'h1, 64'h1 << 31, (64'h7 << 44), 64'h1 << 62, MAX_LENGTH_RESET);
        foreach (dir_tab[i])
            send_word(dir_tab[i].code, dir_tab[i].no_char, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].typed_res);

        set_config(1'b1, {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   (64'h1 << 44) | (64'h1 << 59), 64'h1 << 60, 8'd255);
        send_long_name(256);
        run_names(120);

        // Quiet stretch on both sides.
        set_config(1'b0, '1, '1, '0, '0, MAX_LENGTH_RESET);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_long_name(255);
        run_names(120);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        set_config(1'b0, '0, '0, '1, '1, 8'd0);
        run_names(40);

        set_config(1'b1, {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
                   8'($urandom_range(3, 12)));
        run_names(150);

        // Receiver holds off while short names keep coming, so the block
        // backs up into its input.
        set_config(1'b0, '0, '0, 64'h1 << 44, '0, MAX_LENGTH_RESET);
        tx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(1) != 0)
                send_word(pick_label(1'b0), 1'b0, 1'b0, 1'b0, 1'b0);
            send_word(pick_label(1'b0), 1'b0, 1'b1, 1'b0, 1'b0);
        end
        tx_idle_on = 1'b1;

        set_config(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   8'($urandom_range(16, 255)));
        run_names(100);

        s_valid <= 1'b0;
        while (valid_res_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
hdl/hv_pkg.sv
hdl/hv_front.sv
hdl/hv_queue.sv
hdl/hv_back.sv
hdl/hostname_validator.sv
sim/testbench.sv
